// ----- src/stepper_phase_sequencer_macros.svh -----
// Assertion macros shared by the stepper phase sequencer checker.
`ifndef STEPPER_PHASE_SEQUENCER_MACROS_SVH
`define STEPPER_PHASE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define SPSQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stepper_phase_sequencer check failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define SPSQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stepper_phase_sequencer check failed");

`endif

// ----- src/spsq_pkg.sv -----
// Types, codes and coil tables for the stepper phase sequencer.
package spsq_pkg;

	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_MOVE    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
	localparam logic [1:0] REG_POWER_MODE    = 2'd1;
	localparam logic [1:0] REG_STEP_DELAY    = 2'd2;

	localparam int unsigned CFG_W   = 26;
	localparam int unsigned POS_W   = 15;
	localparam int unsigned DELAY_W = 26;

	localparam logic [POS_W-1:0]   SPR_RESET   = 15'd200;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 26'd5000;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] move_steps;
	} in_item_t;

	typedef struct packed {
		logic [3:0]       coils;
		logic [POS_W-1:0] position;
		logic             busy_res;
		logic             stepped;
		logic             rejected;
	} out_item_t;

	// Single-coil wave pattern for position mod 4.
	function automatic logic [3:0] single_coils(input logic [1:0] phase);
		logic [3:0] c;
		case (phase)
			2'd0:    c = 4'h1;
			2'd1:    c = 4'h4;
			2'd2:    c = 4'h2;
			default: c = 4'h8;
		endcase
		return c;
	endfunction

	// Two-coil power pattern for position mod 4.
	function automatic logic [3:0] power_coils(input logic [1:0] phase);
		logic [3:0] c;
		case (phase)
			2'd0:    c = 4'h5;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'hA;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage

// ----- src/stepper_phase_sequencer.sv -----
// Stepper phase sequencer top level: move control, position and coil drive.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | in_item  (action, move_steps)
//  out     | out | out_valid / out_stall| out_item (coils, position, flags)
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// State and the result register update at the edge that accepts an item, so one
// item per cycle is sustained while out_stall does not hold a waiting result. The
// single result register puts the result out in the cycle after the item is
// accepted. in_stall is high only while a result waits and out_stall holds it.
// Reset clears the move state and loads the register defaults.
module stepper_phase_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  spsq_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output spsq_pkg::out_item_t                out_item,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [spsq_pkg::CFG_W-1:0]         cfg_data
);

	logic [spsq_pkg::POS_W-1:0]   spr_q;
	logic                         power_mode_q;
	logic [spsq_pkg::DELAY_W-1:0] step_delay_q;

	logic [spsq_pkg::POS_W-1:0]   pos_q;
	logic [15:0]                  steps_left_q;
	logic [spsq_pkg::DELAY_W-1:0] delay_q;
	logic                         backward_q;
	logic                         released_q;

	logic                         out_valid_q;
	spsq_pkg::out_item_t          out_item_q;

	logic                         accept;
	logic                         busy;
	logic                         do_step;
	logic                         rejected;
	logic                         dir_nxt;
	logic [15:0]                  mag;
	logic [15:0]                  steps_left_nxt;
	logic [spsq_pkg::DELAY_W-1:0] delay_nxt;
	logic                         released_nxt;
	logic [spsq_pkg::POS_W-1:0]   rev_len;
	logic [spsq_pkg::POS_W:0]     pos_inc;
	logic [spsq_pkg::POS_W-1:0]   pos_step;
	logic [spsq_pkg::POS_W-1:0]   pos_nxt;
	logic [3:0]                   coils_nxt;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign busy     = steps_left_q != 16'd0;

	// A zero steps-per-revolution setting behaves as a one-step revolution.
	assign rev_len = (spr_q == '0) ? spsq_pkg::POS_W'(1) : spr_q;
	assign pos_inc = {1'b0, pos_q} + (spsq_pkg::POS_W+1)'(1);

	always_comb begin
		do_step        = 1'b0;
		rejected       = 1'b0;
		dir_nxt        = backward_q;
		mag            = in_item.move_steps[15] ? 16'(-in_item.move_steps)
		                                        : in_item.move_steps;
		steps_left_nxt = steps_left_q;
		delay_nxt      = delay_q;
		released_nxt   = released_q;
		case (in_item.action)
			spsq_pkg::ACT_TICK: begin
				if (busy) begin
					if (delay_q > spsq_pkg::DELAY_W'(1)) begin
						delay_nxt = delay_q - spsq_pkg::DELAY_W'(1);
					end else begin
						do_step        = 1'b1;
						steps_left_nxt = steps_left_q - 16'd1;
					end
				end
			end
			spsq_pkg::ACT_MOVE: begin
				if (busy) begin
					rejected = 1'b1;
				end else if (in_item.move_steps != 16'sd0) begin
					do_step        = 1'b1;
					dir_nxt        = in_item.move_steps[15];
					steps_left_nxt = mag - 16'd1;
				end
			end
			spsq_pkg::ACT_RELEASE: begin
				released_nxt   = 1'b1;
				steps_left_nxt = 16'd0;
				delay_nxt      = '0;
			end
			default: begin
			end
		endcase
		if (do_step) begin
			released_nxt = 1'b0;
			delay_nxt    = (steps_left_nxt != 16'd0) ? step_delay_q : '0;
		end
	end

	// One step in the chosen direction, wrapping within the revolution, and the coils for the result.
	always_comb begin
		if (dir_nxt) begin
			if (pos_q == '0 || pos_q >= rev_len)
				pos_step = rev_len - spsq_pkg::POS_W'(1);
			else
				pos_step = pos_q - spsq_pkg::POS_W'(1);
		end else begin
			if (pos_inc >= {1'b0, rev_len})
				pos_step = '0;
			else
				pos_step = pos_inc[spsq_pkg::POS_W-1:0];
		end
		pos_nxt = do_step ? pos_step : pos_q;
		if (released_nxt)
			coils_nxt = 4'h0;
		else if (power_mode_q)
			coils_nxt = spsq_pkg::power_coils(pos_nxt[1:0]);
		else
			coils_nxt = spsq_pkg::single_coils(pos_nxt[1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q        <= spsq_pkg::SPR_RESET;
			power_mode_q <= 1'b0;
			step_delay_q <= spsq_pkg::DELAY_RESET;
			pos_q        <= '0;
			steps_left_q <= 16'd0;
			delay_q      <= '0;
			backward_q   <= 1'b0;
			released_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				pos_q        <= pos_nxt;
				steps_left_q <= steps_left_nxt;
				delay_q      <= delay_nxt;
				backward_q   <= dir_nxt;
				released_q   <= released_nxt;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q  <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					spsq_pkg::REG_STEPS_PER_REV: begin
						spr_q <= cfg_data[spsq_pkg::POS_W-1:0];
						pos_q <= '0;
					end
					spsq_pkg::REG_POWER_MODE: power_mode_q <= cfg_data[0];
					spsq_pkg::REG_STEP_DELAY: step_delay_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.coils    <= coils_nxt;
			out_item_q.position <= pos_nxt;
			out_item_q.busy_res <= steps_left_nxt != 16'd0;
			out_item_q.stepped  <= do_step;
			out_item_q.rejected <= rejected;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- src/spsq_checker.sv -----
// Port-level checker for the stepper phase sequencer and its bind.
`include "stepper_phase_sequencer_macros.svh"

module spsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input spsq_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input spsq_pkg::out_item_t out_item
);

	logic release_taken;
	logic idle_off;

	assign release_taken = in_valid && !in_stall && in_item.action == spsq_pkg::ACT_RELEASE;
	assign idle_off      = out_item.coils == 4'h0 && !out_item.busy_res && !out_item.stepped;

	// A waiting result holds until taken.
	`SPSQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

	// The input side is held back only by a result that is itself held.
	`SPSQ_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)

	// A rejected move leaves the running move alone and takes no step.
	`SPSQ_ASSERT_NOW(a_reject, out_valid && out_item.rejected, out_item.busy_res && !out_item.stepped)

	// A release shows up in the very next result as idle, de-energized coils.
	`SPSQ_ASSERT_NEXT(a_release, release_taken, out_valid && idle_off)

endmodule

bind stepper_phase_sequencer spsq_checker u_spsq_checker (.*);
